// ===== rtl/clook_disk_request_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CLOOK_DISK_REQUEST_SCHEDULER_MACROS_SVH
`define CLOOK_DISK_REQUEST_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define CLOOK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside of reset.
`define CLOOK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/clook_pkg.sv =====
package clook_pkg;

	// Fixed widths of the result fields.
	localparam int OUT_W   = 16;
	localparam int TOTAL_W = 21;

	// Command codes on the input channel.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LD_RD,
		S_LD_CMP,
		S_FD_RD,
		S_FD_CMP,
		S_SV_RD,
		S_SV_CALC,
		S_SV_OUT
	} state_t;

endpackage

// ===== rtl/clook_mem.sv =====
module clook_mem #(
	parameter int DEPTH  = 32,
	parameter int DATA_W = 16,
	parameter int ADDR_W = 5
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// One write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// One read port with registered data.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/clook_alu.sv =====
module clook_alu #(
	parameter int W = 16
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         lt,
	output logic [W-1:0] abs_diff
);

	logic [W:0] diff;

	// One subtractor serves both the ordering compare and the distance.
	assign diff     = {1'b0, a} - {1'b0, b};
	assign lt       = diff[W];
	assign abs_diff = lt ? (~diff[W-1:0] + W'(1)) : diff[W-1:0];

endmodule

// ===== rtl/clook_disk_request_scheduler.sv =====
// Channel | Dir | Handshake           | Words
// in      | in  | in_valid/in_ready   | cmd, track, move_left
// out     | out | out_valid/out_ready | from_track, to_track, movement, total_movement, last
//
// A load moves each stored request above the new track up one slot, then writes the
// track in its place. A load into a full memory or a start with no requests is dropped.
// A start takes the head, searches past the stored requests below it, then reads,
// computes and presents each result in turn, waiting while out_ready stays
// low; in_ready is low until the run ends. Reset clears the state and request count only.
// A stalled result holds in its output register and the sequencer waits on it.
`include "clook_disk_request_scheduler_macros.svh"

module clook_disk_request_scheduler #(
	parameter int MAX_REQUESTS = 32,
	parameter int TRACK_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [TRACK_BITS-1:0]        track,
	input  logic                         move_left,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [clook_pkg::OUT_W-1:0]   from_track,
	output logic [clook_pkg::OUT_W-1:0]   to_track,
	output logic [clook_pkg::OUT_W-1:0]   movement,
	output logic [clook_pkg::TOTAL_W-1:0] total_movement,
	output logic                         last
);

	localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
	localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;

	clook_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      i_q;
	logic [CNT_W-1:0]      j_q;
	logic [CNT_W-1:0]      k_q;
	logic [TRACK_BITS-1:0] trk_q;
	logic                  left_q;
	logic [TRACK_BITS-1:0] head_q;
	logic [clook_pkg::TOTAL_W-1:0] total_q;
	logic [clook_pkg::OUT_W-1:0]   from_q;
	logic [clook_pkg::OUT_W-1:0]   to_q;
	logic [clook_pkg::OUT_W-1:0]   mv_q;
	logic                  last_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [TRACK_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]      mem_raddr;
	logic [TRACK_BITS-1:0] mem_rdata;

	logic [TRACK_BITS-1:0] alu_a;
	logic [TRACK_BITS-1:0] alu_b;
	logic                  alu_lt;
	logic [TRACK_BITS-1:0] alu_abs;

	logic                  in_acc;
	logic                  out_acc;
	logic [CNT_W-1:0]      i_m1;
	logic [CNT_W:0]        sum_r;
	logic [CNT_W:0]        dif_l;
	logic [CNT_W:0]        idx_r;
	logic [CNT_W:0]        idx_l;
	logic [IDX_W-1:0]      sv_idx;
	logic [clook_pkg::OUT_W-1:0] mv16;
	logic                  last_d;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign i_m1    = i_q - CNT_W'(1);

	// Serve order: right runs j..n-1 then 0..j-1, left runs j-1..0 then n-1..j.
	assign sum_r  = {1'b0, j_q} + {1'b0, k_q};
	assign idx_r  = (sum_r >= {1'b0, cnt_q}) ? (sum_r - {1'b0, cnt_q}) : sum_r;
	assign dif_l  = {1'b0, j_q} - {1'b0, k_q} - (CNT_W + 1)'(1);
	assign idx_l  = dif_l[CNT_W] ? (dif_l + {1'b0, cnt_q}) : dif_l;
	assign sv_idx = left_q ? idx_l[IDX_W-1:0] : idx_r[IDX_W-1:0];

	assign mv16   = clook_pkg::OUT_W'(alu_abs);
	assign last_d = (k_q == (cnt_q - CNT_W'(1)));

	clook_mem #(
		.DEPTH  (MAX_REQUESTS),
		.DATA_W (TRACK_BITS),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	clook_alu #(
		.W (TRACK_BITS)
	) u_alu (
		.a        (alu_a),
		.b        (alu_b),
		.lt       (alu_lt),
		.abs_diff (alu_abs)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clook_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory control and shared unit operands.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = i_q[IDX_W-1:0];
		mem_wdata = trk_q;
		mem_raddr = i_m1[IDX_W-1:0];
		alu_a     = mem_rdata;
		alu_b     = head_q;
		case (state_q)
			clook_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (cmd == clook_pkg::CMD_LOAD) begin
						if (cnt_q != CNT_W'(MAX_REQUESTS)) begin
							state_d = clook_pkg::S_LD_RD;
						end
					end else if (cnt_q != '0) begin
						state_d = clook_pkg::S_FD_RD;
					end
				end
			end
			clook_pkg::S_LD_RD: begin
				if (i_q == '0) begin
					mem_we  = 1'b1;
					state_d = clook_pkg::S_IDLE;
				end else begin
					state_d = clook_pkg::S_LD_CMP;
				end
			end
			clook_pkg::S_LD_CMP: begin
				alu_a  = trk_q;
				alu_b  = mem_rdata;
				mem_we = 1'b1;
				if (alu_lt) begin
					mem_wdata = mem_rdata;
					state_d   = clook_pkg::S_LD_RD;
				end else begin
					state_d = clook_pkg::S_IDLE;
				end
			end
			clook_pkg::S_FD_RD: begin
				mem_raddr = j_q[IDX_W-1:0];
				if (j_q == cnt_q) begin
					state_d = clook_pkg::S_SV_RD;
				end else begin
					state_d = clook_pkg::S_FD_CMP;
				end
			end
			clook_pkg::S_FD_CMP: begin
				alu_a = mem_rdata;
				alu_b = trk_q;
				if (alu_lt) begin
					state_d = clook_pkg::S_FD_RD;
				end else begin
					state_d = clook_pkg::S_SV_RD;
				end
			end
			clook_pkg::S_SV_RD: begin
				mem_raddr = sv_idx;
				state_d   = clook_pkg::S_SV_CALC;
			end
			clook_pkg::S_SV_CALC: begin
				state_d = clook_pkg::S_SV_OUT;
			end
			clook_pkg::S_SV_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = last_q ? clook_pkg::S_IDLE : clook_pkg::S_SV_RD;
				end
			end
			default: begin
				state_d = clook_pkg::S_IDLE;
			end
		endcase
	end

	// Request count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (mem_we && mem_wdata == trk_q &&
				(state_q == clook_pkg::S_LD_RD ||
				(state_q == clook_pkg::S_LD_CMP && !alu_lt))) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			clook_pkg::S_IDLE: begin
				if (in_acc) begin
					trk_q   <= track;
					left_q  <= move_left;
					head_q  <= track;
					i_q     <= cnt_q;
					j_q     <= '0;
					k_q     <= '0;
					total_q <= '0;
				end
			end
			clook_pkg::S_LD_CMP: begin
				if (alu_lt) begin
					i_q <= i_m1;
				end
			end
			clook_pkg::S_FD_CMP: begin
				if (alu_lt) begin
					j_q <= j_q + CNT_W'(1);
				end
			end
			clook_pkg::S_SV_CALC: begin
				from_q  <= clook_pkg::OUT_W'(head_q);
				to_q    <= clook_pkg::OUT_W'(mem_rdata);
				mv_q    <= mv16;
				total_q <= total_q + clook_pkg::TOTAL_W'(mv16);
				last_q  <= last_d;
				head_q  <= mem_rdata;
			end
			clook_pkg::S_SV_OUT: begin
				if (out_acc) begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign from_track     = from_q;
	assign to_track       = to_q;
	assign movement       = mv_q;
	assign total_movement = total_q;
	assign last           = last_q;

	`CLOOK_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= CNT_W'(MAX_REQUESTS), "request count above capacity")
	`CLOOK_ASSERT_NXT(a_load_go, in_acc && cmd == clook_pkg::CMD_LOAD && cnt_q != CNT_W'(MAX_REQUESTS), state_q == clook_pkg::S_LD_RD, "accepted load did not start insertion")
	`CLOOK_ASSERT_NXT(a_last_end, out_acc && last, state_q == clook_pkg::S_IDLE, "run did not end after last word")
	`CLOOK_ASSERT_IMP(a_idx_range, state_q == clook_pkg::S_SV_RD, CNT_W'(sv_idx) < cnt_q, "serve index beyond stored requests")

endmodule
